>>> rtl/sacl_pkg.sv
// Package for the set-associative LRU tag store: sizes, types and codes.
// No dependencies; used by every module in the rtl folder.
`default_nettype none
package sacl_pkg;
    localparam int MAX_SET_INDEX_BITS = 8;
    localparam int MAX_WAYS = 8;
    localparam int NUM_SETS = 1 << MAX_SET_INDEX_BITS;
    localparam int WAY_W = $clog2(MAX_WAYS);
    localparam int RANK_W = WAY_W;
    localparam int TAG_W = 63;
    localparam int ADDR_W = 64;
    localparam int CNT_W = 32;

    typedef logic [MAX_SET_INDEX_BITS-1:0] t_set;
    typedef logic [TAG_W-1:0]              t_tag;
    typedef logic [RANK_W-1:0]             t_rank;

    typedef enum logic [1:0] {
        KIND_IFETCH = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_STORE  = 2'd2,
        KIND_MODIFY = 2'd3
    } t_kind;

    localparam logic [1:0] REG_SET_BITS = 2'd0;
    localparam logic [1:0] REG_OFF_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the request, start set read
        logic clr_acc;  // clear per-request flags
        logic update;   // compare and write back the set
        logic reread;   // read the set again for the second access
        logic finish;   // bump eviction counter, load output register
    } t_cmd;
endpackage
`default_nettype wire

>>> rtl/sacl_ctrl.sv
// Controller for the LRU tag store: sequences read, update and result.
// Depends on sacl_pkg.
`default_nettype none
module sacl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    input  wire logic [1:0]    i_kind,
    input  wire logic          i_out_busy,
    input  wire logic          i_clr_busy,
    output sacl_pkg::t_cmd     o_cmd,
    output logic               o_req_ready
);
    import sacl_pkg::*;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_modify, n_modify;

    // next state
    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        n_modify = r_modify;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid && !i_clr_busy) begin
                    n_second = 1'b0;
                    n_modify = (i_kind == KIND_MODIFY);
                    n_state  = (i_kind == KIND_IFETCH) ? ST_OUT : ST_READ;
                end
            end
            ST_READ: n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (r_modify && !r_second) begin
                    n_second = 1'b1;
                    n_state  = ST_READ;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: if (!i_out_busy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_req_ready = (r_state == ST_IDLE) && !i_clr_busy;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load    = i_req_valid && !i_clr_busy;
                o_cmd.clr_acc = i_req_valid && !i_clr_busy;
            end
            ST_READ:   o_cmd = '0;
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                o_cmd.reread = r_modify && !r_second;
            end
            ST_OUT:    o_cmd.finish = !i_out_busy;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_second <= 1'b0;
            r_modify <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_modify <= n_modify;
        end
    end

    a_update_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> $past(r_state == ST_READ))
        else $error("update without a set read");
    a_ready_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> !r_second || r_state == ST_IDLE)
        else $error("ready outside idle");
    a_finish_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> r_state == ST_OUT)
        else $error("finish outside result state");
endmodule
`default_nettype wire

>>> rtl/sacl_dpath.sv
// Datapath for the LRU tag store: set memories, tag compare, rank update
// and saturating counters. Depends on sacl_pkg.
`default_nettype none
module sacl_dpath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  sacl_pkg::t_cmd                 i_cmd,
    input  wire logic [63:0]               i_address,
    input  wire logic [3:0]                i_set_bits,
    input  wire logic [5:0]                i_off_bits,
    input  wire logic [3:0]                i_ways,
    output logic                           o_clr_busy,
    output logic [1:0]                     o_hits_now,
    output logic                           o_missed,
    output logic                           o_evicted,
    output logic [31:0]                    o_total_hits,
    output logic [31:0]                    o_total_misses,
    output logic [31:0]                    o_total_evictions
);
    import sacl_pkg::*;

    // valid bits, tags and ranks as set-wide memories
    logic [MAX_WAYS-1:0]        r_valid_mem [NUM_SETS];
    logic [MAX_WAYS*TAG_W-1:0]  r_tag_mem  [NUM_SETS];
    logic [MAX_WAYS*RANK_W-1:0] r_rank_mem [NUM_SETS];
    logic [MAX_WAYS-1:0]        r_valid_rd;
    logic [MAX_WAYS*TAG_W-1:0]  r_tag_rd;
    logic [MAX_WAYS*RANK_W-1:0] r_rank_rd;

    t_set  r_set;
    t_tag  r_tag;
    logic [3:0] r_ways;
    logic [1:0] r_hits;
    logic r_miss, r_ev;
    logic [CNT_W-1:0] r_cnt_hit, r_cnt_miss, r_cnt_ev;
    logic  r_clr_busy;
    t_set  r_clr_idx;

    assign o_clr_busy = r_clr_busy;

    // address split
    logic [3:0]  sb;
    logic [6:0]  sh_set, sh_tag;
    logic [63:0] a_set, a_tag;
    logic [MAX_SET_INDEX_BITS-1:0] set_mask;
    t_set  n_set;
    always_comb begin
        sb = i_set_bits;
        if (sb == 4'd0) sb = 4'd1;
        if (sb > 4'(MAX_SET_INDEX_BITS)) sb = 4'(MAX_SET_INDEX_BITS);
        sh_set = {1'b0, i_off_bits};
        sh_tag = {1'b0, i_off_bits} + {3'd0, sb};
        a_set  = (sh_set[6]) ? 64'd0 : (i_address >> sh_set[5:0]);
        a_tag  = (sh_tag[6]) ? 64'd0 : (i_address >> sh_tag[5:0]);
        set_mask = MAX_SET_INDEX_BITS'((9'd1 << sb) - 9'd1);
        n_set  = a_set[MAX_SET_INDEX_BITS-1:0] & set_mask;
    end

    // compare and victim selection on the registered set read
    logic [MAX_WAYS-1:0] vrow, hit_vec, n_vrow;
    logic [MAX_WAYS*RANK_W-1:0] n_rank;
    logic hit, found_free;
    logic [WAY_W-1:0] w_sel;
    t_rank old_rank, best, rk;
    logic [RANK_W:0] ref_rank;
    always_comb begin
        vrow = r_valid_rd;
        hit = 1'b0; found_free = 1'b0; w_sel = '0; best = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            hit_vec[i] = (i < int'(r_ways)) && vrow[i] &&
                         r_tag_rd[i*TAG_W +: TAG_W] == r_tag;
        end
        for (int i = MAX_WAYS-1; i >= 0; i--) begin
            if (hit_vec[i]) begin hit = 1'b1; w_sel = WAY_W'(i); end
        end
        if (!hit) begin
            for (int i = MAX_WAYS-1; i >= 0; i--) begin
                if (i < int'(r_ways) && !vrow[i]) begin
                    found_free = 1'b1; w_sel = WAY_W'(i);
                end
            end
            if (!found_free) begin
                for (int i = 0; i < MAX_WAYS; i++) begin
                    rk = r_rank_rd[i*RANK_W +: RANK_W];
                    if (i < int'(r_ways) && (i == 0 || rk > best)) begin
                        best = rk; w_sel = WAY_W'(i);
                    end
                end
            end
        end
        old_rank = r_rank_rd[w_sel*RANK_W +: RANK_W];
        ref_rank = hit ? {1'b0, old_rank} : (RANK_W+1)'(MAX_WAYS);
        n_rank = r_rank_rd;
        n_vrow = vrow;
        n_vrow[w_sel] = 1'b1;
        for (int i = 0; i < MAX_WAYS; i++) begin
            rk = r_rank_rd[i*RANK_W +: RANK_W];
            if (i < int'(r_ways) && WAY_W'(i) != w_sel && vrow[i] &&
                {1'b0, rk} < ref_rank && rk != t_rank'(MAX_WAYS-1))
                n_rank[i*RANK_W +: RANK_W] = rk + t_rank'(1);
        end
        n_rank[w_sel*RANK_W +: RANK_W] = '0;
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

    logic [3:0] ways_c;
    always_comb begin
        ways_c = i_ways;
        if (ways_c == 4'd0) ways_c = 4'd1;
        if (ways_c > 4'(MAX_WAYS)) ways_c = 4'(MAX_WAYS);
    end

    // new tag row with the selected way replaced
    logic [MAX_WAYS*TAG_W-1:0] n_tagrow;
    always_comb begin
        n_tagrow = r_tag_rd;
        n_tagrow[w_sel*TAG_W +: TAG_W] = r_tag;
    end

    // clearing pass after reset: one set per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + t_set'(1);
            if (r_clr_idx == t_set'(NUM_SETS-1)) r_clr_busy <= 1'b0;
        end
    end

    // set memories: one write of a whole set, registered read
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_valid_mem[r_clr_idx] <= '0;
            r_rank_mem[r_clr_idx]  <= '0;
        end else if (i_cmd.update) begin
            r_valid_mem[r_set] <= n_vrow;
            r_tag_mem[r_set]   <= n_tagrow;
            r_rank_mem[r_set]  <= n_rank;
        end
        if (i_cmd.load) begin
            r_valid_rd <= r_valid_mem[n_set];
            r_tag_rd   <= r_tag_mem[n_set];
            r_rank_rd  <= r_rank_mem[n_set];
        end else if (i_cmd.reread) begin
            r_valid_rd <= n_vrow;
            r_tag_rd   <= n_tagrow;
            r_rank_rd  <= n_rank;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set  <= n_set;
            r_tag  <= a_tag[TAG_W-1:0];
            r_ways <= ways_c;
        end
    end

    // flags and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0; r_miss <= 1'b0; r_ev <= 1'b0;
            r_cnt_hit <= '0; r_cnt_miss <= '0; r_cnt_ev <= '0;
            o_hits_now <= '0; o_missed <= 1'b0; o_evicted <= 1'b0;
            o_total_hits <= '0; o_total_misses <= '0; o_total_evictions <= '0;
        end else begin
            if (i_cmd.clr_acc) begin
                r_hits <= '0; r_miss <= 1'b0; r_ev <= 1'b0;
            end
            if (i_cmd.update) begin
                if (hit) begin
                    r_hits    <= r_hits + 2'd1;
                    r_cnt_hit <= sat_inc(r_cnt_hit);
                end else begin
                    r_miss     <= 1'b1;
                    r_cnt_miss <= sat_inc(r_cnt_miss);
                    if (!found_free) r_ev <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                o_hits_now        <= r_hits;
                o_missed          <= r_miss;
                o_evicted         <= r_ev;
                o_total_hits      <= r_cnt_hit;
                o_total_misses    <= r_cnt_miss;
                o_total_evictions <= r_ev ? sat_inc(r_cnt_ev) : r_cnt_ev;
                if (r_ev) r_cnt_ev <= sat_inc(r_cnt_ev);
            end
        end
    end

    a_clear_before_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_clr_busy)
        else $error("request taken during clearing pass");
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hits != 2'd3)
        else $error("more than two hits in one request");
    a_ev_needs_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev |-> r_miss)
        else $error("eviction without a miss");
endmodule
`default_nettype wire

>>> rtl/set_assoc_cache_lru_lookup.sv
// Top level of the LRU tag store: configuration, stream ports, controller
// and datapath. Depends on sacl_pkg, sacl_ctrl, sacl_dpath.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata {address[65:2], kind[1:0]}
//  m_axis    | out       | tdata hits/missed/evicted/totals
//  cfg       | in        | index 0 set bits, 1 offset bits, 2 ways
//
// A load or store runs set read, idle step and write back, then registers its
// result, and the next request may be taken from then on; a modify makes two
// read-update passes, a fetch none. The single-port set memory (read, idle
// cycle, write back) sets this.
// After reset a pass over all 256 sets clears valid bits and ranks; requests wait.
// The result register holds while m_axis_tready is low; the next request runs up
// to its result and waits there until the register is free.
`default_nettype none
module set_assoc_cache_lru_lookup (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [71:0]  s_axis_tdata,   // kind[1:0], address[65:2], zero fill
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata,   // hits_now[1:0], missed[2], evicted[3],
                                              // total_hits[35:4], total_misses[67:36],
                                              // total_evictions[99:68], zero fill
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    import sacl_pkg::*;

    logic [3:0] r_set_bits, r_ways;
    logic [5:0] r_off_bits;
    logic       r_out_valid;
    t_cmd       cmd;
    logic       req_ready;
    logic       clr_busy;
    logic [1:0]  hits_now;
    logic        missed, evicted;
    logic [31:0] th, tm, te;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= 4'd4;
            r_off_bits <= 6'd4;
            r_ways     <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SET_BITS: r_set_bits <= i_cfg_data[3:0];
                REG_OFF_BITS: r_off_bits <= i_cfg_data[5:0];
                REG_WAYS:     r_ways     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = req_ready;

    sacl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_kind      (s_axis_tdata[1:0]),
        .i_out_busy  (r_out_valid),
        .i_clr_busy  (clr_busy),
        .o_cmd       (cmd),
        .o_req_ready (req_ready)
    );

    sacl_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_address         (s_axis_tdata[65:2]),
        .i_set_bits        (r_set_bits),
        .i_off_bits        (r_off_bits),
        .i_ways            (r_ways),
        .o_clr_busy        (clr_busy),
        .o_hits_now        (hits_now),
        .o_missed          (missed),
        .o_evicted         (evicted),
        .o_total_hits      (th),
        .o_total_misses    (tm),
        .o_total_evictions (te)
    );

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (cmd.finish) r_out_valid <= 1'b1;
        else if (m_axis_tready) r_out_valid <= 1'b0;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, te, tm, th, evicted, missed, hits_now};

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> cmd.load)
        else $error("request accepted without capture");
    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> r_out_valid)
        else $error("result lost");
    a_no_finish_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> !r_out_valid)
        else $error("result overwritten");
endmodule
`default_nettype wire

>>> bench/set_assoc_cache_lru_lookup_test.sv
// Self-checking bench for the set-associative LRU tag store: directed table, then
// random access streams, every result checked against a behavioural tag-store model.
// Depends on sacl_pkg and set_assoc_cache_lru_lookup.
`default_nettype none
module set_assoc_cache_lru_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sacl_pkg::*;

    localparam int LATENCY_PAD = 20;

    typedef struct packed {
        logic [1:0]  hits_now;
        logic        missed;
        logic        evicted;
        logic [31:0] total_hits;
        logic [31:0] total_misses;
        logic [31:0] total_evictions;
    } t_outcome;

    // one directed row: request plus optional typed-in outcome
    typedef struct {
        t_kind       kind;
        logic [63:0] addr;
        bit          known;
        t_outcome    want;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    set_assoc_cache_lru_lookup uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("set_assoc_cache_lru_lookup regression: fail");
        $finish;
    end

    // shadow tag store and configuration
    logic [3:0]  shadow_set_bits;
    logic [5:0]  shadow_off_bits;
    logic [3:0]  shadow_ways;
    bit          line_ok  [NUM_SETS][MAX_WAYS];
    logic [63:0] line_tg  [NUM_SETS][MAX_WAYS];
    int unsigned line_age [NUM_SETS][MAX_WAYS];
    logic [31:0] sum_hits, sum_misses, sum_evicts;

    t_outcome    outcome_q[$];
    int          errors = 0;
    int          outcomes_seen = 0;
    int          sent = 0;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
                 outcomes_seen);
    endtask

    // field-by-field comparison of two outcomes
    task automatic check_outcome(input string where, input t_outcome got,
                                 input t_outcome want);
        if (got.hits_now != want.hits_now)
            report({where, " hits_now"}, 64'(got.hits_now), 64'(want.hits_now));
        if (got.missed != want.missed)
            report({where, " missed"}, 64'(got.missed), 64'(want.missed));
        if (got.evicted != want.evicted)
            report({where, " evicted"}, 64'(got.evicted), 64'(want.evicted));
        if (got.total_hits != want.total_hits)
            report({where, " total_hits"}, 64'(got.total_hits), 64'(want.total_hits));
        if (got.total_misses != want.total_misses)
            report({where, " total_misses"}, 64'(got.total_misses),
                   64'(want.total_misses));
        if (got.total_evictions != want.total_evictions)
            report({where, " total_evictions"}, 64'(got.total_evictions),
                   64'(want.total_evictions));
    endtask

    function automatic logic [31:0] sat_bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void shadow_reset();
        shadow_set_bits = 4'd4;
        shadow_off_bits = 6'd4;
        shadow_ways = 4'd1;
        foreach (line_ok[s, w]) begin
            line_ok[s][w] = 1'b0;
            line_tg[s][w] = '0;
            line_age[s][w] = 0;
        end
        sum_hits = '0;
        sum_misses = '0;
        sum_evicts = '0;
    endfunction

    // make way w most recent, ageing valid ways that were newer than it
    function automatic void promote(int s, int nw, int w, int unsigned prev);
        for (int i = 0; i < nw; i++)
            if (i != w && line_ok[s][i] && line_age[s][i] < prev && line_age[s][i] < MAX_WAYS - 1)
                line_age[s][i]++;
        line_age[s][w] = 0;
    endfunction

    // one lookup; returns 1 on hit
    function automatic bit lookup_line(input logic [63:0] addr, ref bit evict);
        int sb, nw, s, victim;
        int unsigned oldest;
        logic [63:0] tg;
        bit free_found;
        sb = (shadow_set_bits < 1) ? 1 : (shadow_set_bits > MAX_SET_INDEX_BITS) ?
             MAX_SET_INDEX_BITS : shadow_set_bits;
        nw = (shadow_ways < 1) ? 1 : (shadow_ways > MAX_WAYS) ? MAX_WAYS : shadow_ways;
        s = int'((shadow_off_bits >= 64 ? 64'd0 : addr >> shadow_off_bits)
                 & ((64'd1 << sb) - 1));
        tg = (shadow_off_bits + sb >= 64) ? 64'd0 : addr >> (shadow_off_bits + sb);
        for (int i = 0; i < nw; i++)
            if (line_ok[s][i] && line_tg[s][i] == tg) begin
                promote(s, nw, i, line_age[s][i]);
                return 1'b1;
            end
        victim = 0;
        free_found = 1'b0;
        for (int i = 0; i < nw; i++)
            if (!line_ok[s][i]) begin
                victim = i;
                free_found = 1'b1;
                break;
            end
        if (!free_found) begin
            oldest = line_age[s][0];
            for (int i = 1; i < nw; i++)
                if (line_age[s][i] > oldest) begin
                    oldest = line_age[s][i];
                    victim = i;
                end
            evict = 1'b1;
        end
        line_ok[s][victim] = 1'b1;
        line_tg[s][victim] = tg;
        promote(s, nw, victim, MAX_WAYS);
        return 1'b0;
    endfunction

    function automatic t_outcome predict_access(t_kind kind, logic [63:0] addr);
        t_outcome o;
        int n;
        bit evict;
        o = '0;
        evict = 1'b0;
        n = (kind == KIND_IFETCH) ? 0 : (kind == KIND_MODIFY) ? 2 : 1;
        for (int r = 0; r < n; r++)
            if (lookup_line(addr, evict)) begin
                o.hits_now++;
                sum_hits = sat_bump(sum_hits);
            end else begin
                o.missed = 1'b1;
                sum_misses = sat_bump(sum_misses);
            end
        if (evict) sum_evicts = sat_bump(sum_evicts);
        o.evicted = evict;
        o.total_hits = sum_hits;
        o.total_misses = sum_misses;
        o.total_evictions = sum_evicts;
        return o;
    endfunction

    // idle gap: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_access(t_kind kind, logic [63:0] addr, bit known, t_outcome want);
        t_outcome o;
        o = predict_access(kind, addr);
        if (known) begin
            check_outcome("table row vs predictor", o, want);
        end
        outcome_q.push_back(o);
        s_axis_tdata = {6'd0, addr, kind};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        sent++;
    endtask

    task automatic wait_drained();
        while (outcome_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY_PAD) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_index = idx;
        i_cfg_data = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx == REG_SET_BITS) shadow_set_bits = val[3:0];
        else if (idx == REG_OFF_BITS) shadow_off_bits = val[5:0];
        else if (idx == REG_WAYS) shadow_ways = val[3:0];
    endtask

    task automatic configure(int sb, int ob, int nw);
        wait_drained();
        write_reg(REG_SET_BITS, sb);
        write_reg(REG_OFF_BITS, ob);
        write_reg(REG_WAYS, nw);
    endtask

    // random address confined to a few tags per set so hits and evictions occur
    function automatic logic [63:0] pick_addr();
        logic [63:0] a;
        a = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 8) begin
            a = a & 64'h0000_0000_0000_7FFF;
            a[63:60] = 4'($urandom_range(0, 3));
        end
        return a;
    endfunction

    task automatic random_phase(int count);
        t_kind kind;
        for (int i = 0; i < count; i++) begin
            repeat (pick_gap()) @(negedge i_clk);
            kind = t_kind'($urandom_range(0, 3));
            send_access(kind, pick_addr(), 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hits_now        = m_axis_tdata[1:0];
            got.missed          = m_axis_tdata[2];
            got.evicted         = m_axis_tdata[3];
            got.total_hits      = m_axis_tdata[35:4];
            got.total_misses    = m_axis_tdata[67:36];
            got.total_evictions = m_axis_tdata[99:68];
            outcomes_seen++;
            if (outcome_q.size() == 0) begin
                report("unexpected result", 64'(got.total_hits), 64'd0);
            end else begin
                want = outcome_q.pop_front();
                check_outcome("result", got, want);
            end
        end
    end

    // receiver back-pressure, with one long hold-off stretch on request
    initial begin
        int gap;
        @(posedge i_rst_n);
        while (!stim_done || outcome_q.size() != 0) begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0 && $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    t_row rows[$];

    function automatic t_outcome mk(int h, int m, int e, int th, int tm, int te);
        t_outcome o;
        o.hits_now = 2'(h);
        o.missed = 1'(m);
        o.evicted = 1'(e);
        o.total_hits = th;
        o.total_misses = tm;
        o.total_evictions = te;
        return o;
    endfunction

    initial begin
        shadow_reset();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows, reset config (16 sets, 16-byte blocks, one way)
        rows.push_back('{KIND_IFETCH, 64'h0, 1'b1, mk(0, 0, 0, 0, 0, 0)});
        rows.push_back('{KIND_LOAD, 64'h0, 1'b1, mk(0, 1, 0, 0, 1, 0)});
        rows.push_back('{KIND_STORE, 64'hF, 1'b1, mk(1, 0, 0, 1, 1, 0)});
        rows.push_back('{KIND_MODIFY, 64'h100, 1'b1, mk(1, 1, 1, 2, 2, 1)});
        rows.push_back('{KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, mk(0, 1, 0, 2, 3, 1)});
        rows.push_back('{KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, mk(2, 0, 0, 4, 3, 1)});
        rows.push_back('{KIND_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, mk(0, 0, 0, 4, 3, 1)});
        rows.push_back('{KIND_LOAD, 64'h8000_0000_0000_0000, 1'b0, '0});
        rows.push_back('{KIND_STORE, 64'h5555_5555_5555_5555, 1'b0, '0});
        rows.push_back('{KIND_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0});
        foreach (rows[i]) send_access(rows[i].kind, rows[i].addr, rows[i].known, rows[i].want);

        // four ways: fill a set, touch, then force LRU eviction
        configure(2, 4, 4);
        for (int i = 0; i < 6; i++) send_access(KIND_LOAD, 64'(i) << 6, 1'b0, '0);
        send_access(KIND_LOAD, 64'h80, 1'b0, '0);
        send_access(KIND_MODIFY, 64'h1C0, 1'b0, '0);
        send_access(KIND_LOAD, 64'h40, 1'b0, '0);

        // shrink ways with lines valid: rank ties
        configure(2, 4, 2);
        for (int i = 0; i < 4; i++) send_access(KIND_LOAD, 64'(i) << 6, 1'b0, '0);

        // out-of-range and wide-offset settings
        configure(0, 63, 0);
        send_access(KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
        send_access(KIND_LOAD, 64'h1, 1'b0, '0);
        configure(15, 60, 15);
        send_access(KIND_STORE, 64'hF000_0000_0000_0000, 1'b0, '0);
        send_access(KIND_STORE, 64'h7000_0000_0000_0000, 1'b0, '0);

        // random phases over several settings, extremes included
        configure(8, 1, 8);
        random_phase(170);
        configure(1, 32, 1);
        random_phase(120);
        // long receiver hold-off while requests keep coming
        hold_off = 1'b1;
        configure(3, 5, 3);
        random_phase(170);
        // sender pauses until everything is back
        wait_drained();
        configure(4, 2, 8);
        random_phase(170);
        configure(6, 10, 5);
        random_phase(190);

        stim_done = 1'b1;
        wait_drained();
        $display("Covered %0d requests over fetch/load/store/modify, fills, LRU evictions,",
                 sent);
        $display("rank ties and clamped or wide-offset settings; %0d results checked.",
                 outcomes_seen);
        if (errors == 0) begin
            $display("set_assoc_cache_lru_lookup regression: pass");
        end else begin
            $display("set_assoc_cache_lru_lookup regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
rtl/sacl_pkg.sv
rtl/sacl_ctrl.sv
rtl/sacl_dpath.sv
rtl/set_assoc_cache_lru_lookup.sv
bench/set_assoc_cache_lru_lookup_test.sv
